@@ rtl/horner_polynomial_evaluator_macros.svh @@
// Assertion helpers for the polynomial evaluator.
// Both sample on clk and are switched off while rst_n is low.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polynomial evaluator check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define HPE_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("polynomial evaluator latency check failed");

`endif

@@ rtl/hpe_pkg.sv @@
`timescale 1ns / 1ps

package hpe_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned NUM_COEF      = 8;
    localparam int unsigned COEF_IDX_W    = $clog2(NUM_COEF);
    localparam int unsigned ADDR_W        = COEF_IDX_W + 2;
    localparam int unsigned DEGREE_DEF    = 7;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t coef_array_t [NUM_COEF];

    // What one cell hands to the next in every cycle.
    typedef struct packed {
        logic  valid;
        logic  ovf;
        word_t x;
        word_t acc;
    } stage_t;

endpackage

@@ rtl/hpe_regs.sv @@
`timescale 1ns / 1ps

module hpe_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [hpe_pkg::WORD_W-1:0]    pwdata,
    output logic [hpe_pkg::WORD_W-1:0]    prdata,
    output logic                          pready,
    output hpe_pkg::coef_array_t          coef
);

    hpe_pkg::coef_array_t                coef_reg;
    logic                                wr_en;
    logic [hpe_pkg::COEF_IDX_W-1:0]      wr_idx;

    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[hpe_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = coef_reg[wr_idx];
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpe_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[wr_idx] <= pwdata;
        end
    end

endmodule

@@ rtl/hpe_cell.sv @@
`timescale 1ns / 1ps

module hpe_cell
#(
    parameter int unsigned FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hpe_pkg::stage_t  up,
    input  hpe_pkg::word_t   coef,
    output hpe_pkg::stage_t  down
);

    localparam int unsigned PROD_W = 2 * hpe_pkg::WORD_W;
    localparam logic signed [PROD_W-1:0] SAT_MAX =
        {{(hpe_pkg::WORD_W + 1){1'b0}}, {(hpe_pkg::WORD_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN =
        {{(hpe_pkg::WORD_W + 1){1'b1}}, {(hpe_pkg::WORD_W - 1){1'b0}}};

    // Multiply stage.
    logic                     mul_valid_reg;
    logic                     mul_ovf_reg;
    hpe_pkg::word_t           mul_x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Scale, add and saturate stage.
    logic                     out_valid_reg;
    logic                     out_ovf_reg;
    hpe_pkg::word_t           out_x_reg;
    hpe_pkg::word_t           out_acc_reg;
    hpe_pkg::word_t           acc_next;
    logic                     ovf_next;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] coef_ext;
    logic signed [PROD_W-1:0] sum;

    assign prod_next = up.acc * up.x;

    always_comb
    begin
        // The arithmetic shift floors toward minus infinity.
        shifted  = prod_reg >>> FRAC_BITS;
        coef_ext = {{hpe_pkg::WORD_W{coef[hpe_pkg::WORD_W-1]}}, coef};
        sum      = shifted + coef_ext;
        ovf_next = mul_ovf_reg;
        if (sum > SAT_MAX)
        begin
            acc_next = SAT_MAX[hpe_pkg::WORD_W-1:0];
            ovf_next = 1'b1;
        end
        else if (sum < SAT_MIN)
        begin
            acc_next = SAT_MIN[hpe_pkg::WORD_W-1:0];
            ovf_next = 1'b1;
        end
        else
        begin
            acc_next = sum[hpe_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= up.valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_ovf_reg <= up.ovf;
        mul_x_reg   <= up.x;
        prod_reg    <= prod_next;
        out_ovf_reg <= ovf_next;
        out_x_reg   <= mul_x_reg;
        out_acc_reg <= acc_next;
    end

    assign down.valid = out_valid_reg;
    assign down.ovf   = out_ovf_reg;
    assign down.x     = out_x_reg;
    assign down.acc   = out_acc_reg;

endmodule

@@ rtl/horner_polynomial_evaluator.sv @@
`timescale 1ns / 1ps
// Each accepted point passes through the DEGREE cells in order; each cell has a
// multiplier register followed by a scale, add and saturate register, and done
// is high for a single cycle when the result comes out.
// Throughput: one point per cycle; busy stays low and results cannot be stalled.
// Reset clears the pipeline valid bits and sets all eight coefficients to zero.
`include "horner_polynomial_evaluator_macros.svh"

module horner_polynomial_evaluator
#(
    parameter int unsigned DEGREE    = hpe_pkg::DEGREE_DEF,
    parameter int unsigned FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          x_value,
    output logic                        done,
    output logic signed [31:0]          y_value,
    output logic                        overflow,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpe_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned LATENCY = 2 * DEGREE;

    hpe_pkg::coef_array_t coef;
    hpe_pkg::stage_t      chain [DEGREE+1];
    logic                 accept;

    hpe_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The accumulator enters the chain holding the leading coefficient.
    assign chain[0].valid = accept;
    assign chain[0].ovf   = 1'b0;
    assign chain[0].x     = x_value;
    assign chain[0].acc   = coef[DEGREE];

    for (genvar i = 0; i < DEGREE; i++)
    begin : g_cell
        hpe_cell
        #(
            .FRAC_BITS (FRAC_BITS)
        )
        u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (chain[i]),
            .coef  (coef[DEGREE-1-i]),
            .down  (chain[i+1])
        );
    end

    assign done     = chain[DEGREE].valid;
    assign y_value  = chain[DEGREE].acc;
    assign overflow = chain[DEGREE].ovf;

    `HPE_ASSERT_DELAY(a_accept_gives_done, accept, LATENCY, done)
    `HPE_ASSERT_IMPL(a_done_has_source, done, $past(accept, LATENCY))

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int DEGREE      = hpe_pkg::DEGREE_DEF;
    localparam int FRAC        = hpe_pkg::FRAC_BITS_DEF;
    localparam int COEF_STRIDE = 4;
    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 100;
    // About 830 points under the heaviest idling, plus the register loads,
    // stays far below this.
    localparam int CYCLE_LIMIT = 200000;

    localparam hpe_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam hpe_pkg::word_t WORD_MIN = 32'sh8000_0000;
    localparam hpe_pkg::word_t ONE_LSB  = 32'sh0000_0001;
    localparam hpe_pkg::word_t MINUS_LSB = 32'shFFFF_FFFF;
    localparam hpe_pkg::word_t ONE_Q16  = 32'sh0001_0000;

    typedef struct packed {
        hpe_pkg::word_t y;
        logic           ovf;
    } poly_result_t;

    typedef struct packed {
        logic [2:0]     coef_sel;
        hpe_pkg::word_t x;
        logic           typed;
        hpe_pkg::word_t y;
        logic           ovf;
    } point_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    hpe_pkg::word_t              x_value = '0;
    logic                        done;
    logic signed [31:0]          y_value;
    logic                        overflow;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [hpe_pkg::ADDR_W-1:0]  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Expectation attached to the point currently on the input ports.
    logic                        drv_typed = 1'b0;
    hpe_pkg::word_t              drv_y = '0;
    logic                        drv_ovf = 1'b0;

    hpe_pkg::word_t              coef_model [hpe_pkg::NUM_COEF];
    poly_result_t                pending_values [$];
    int                          fail_count = 0;
    int                          cycle_count = 0;

    // Coefficient sets for the directed part; set 0 is the reset state.
    hpe_pkg::word_t coef_sets [7][hpe_pkg::NUM_COEF] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{32'sh1234_5678, 0, 0, 0, 0, 0, 0, 0},
        '{0, ONE_Q16, 0, 0, 0, 0, 0, 0},
        '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX},
        '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN},
        '{0, MINUS_LSB, 0, 0, 0, 0, 0, 0},
        '{32'sh0001_0000, 32'shFFFF_8000, 32'sh0000_4000, 32'shFFFF_F000,
          32'sh0000_0400, 32'shFFFF_FF00, 32'sh0000_0010, MINUS_LSB}
    };

    point_row_t directed_rows [NUM_DIRECTED] = '{
        // Reset coefficients: everything evaluates to zero.
        '{3'd0, WORD_MAX,  1'b1, 32'sh0, 1'b0},
        '{3'd0, WORD_MIN,  1'b1, 32'sh0, 1'b0},
        // Constant polynomial.
        '{3'd1, WORD_MAX,  1'b1, 32'sh1234_5678, 1'b0},
        '{3'd1, WORD_MIN,  1'b1, 32'sh1234_5678, 1'b0},
        '{3'd1, 32'sh0,    1'b1, 32'sh1234_5678, 1'b0},
        // p(x) = x passes the extremes through unchanged.
        '{3'd2, WORD_MAX,  1'b1, WORD_MAX, 1'b0},
        '{3'd2, WORD_MIN,  1'b1, WORD_MIN, 1'b0},
        '{3'd2, MINUS_LSB, 1'b1, MINUS_LSB, 1'b0},
        // All coefficients at the positive limit.
        '{3'd3, WORD_MAX,  1'b1, WORD_MAX, 1'b1},
        '{3'd3, WORD_MIN,  1'b1, WORD_MIN, 1'b1},
        '{3'd3, 32'sh0,    1'b1, WORD_MAX, 1'b0},
        '{3'd3, ONE_Q16,   1'b1, WORD_MAX, 1'b1},
        // All coefficients at the negative limit.
        '{3'd4, WORD_MAX,  1'b1, WORD_MIN, 1'b1},
        '{3'd4, 32'sh0,    1'b1, WORD_MIN, 1'b0},
        '{3'd4, MINUS_LSB, 1'b0, 32'sh0, 1'b0},
        // Product scaling rounds toward minus infinity.
        '{3'd5, ONE_LSB,   1'b1, MINUS_LSB, 1'b0},
        '{3'd5, ONE_Q16,   1'b1, MINUS_LSB, 1'b0},
        '{3'd5, MINUS_LSB, 1'b1, 32'sh0, 1'b0},
        // Mixed-sign coefficients across all eight terms.
        '{3'd6, 32'sh0001_8000, 1'b0, 32'sh0, 1'b0},
        '{3'd6, 32'shFFFE_0000, 1'b0, 32'sh0, 1'b0},
        '{3'd6, 32'sh0003_4567, 1'b0, 32'sh0, 1'b0}
    };

    int idle_schedule [3] = '{0, 80, 32};

    horner_polynomial_evaluator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .x_value  (x_value),
        .done     (done),
        .y_value  (y_value),
        .overflow (overflow),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Horner evaluation with per-step saturation; the shift floors.
    function automatic poly_result_t eval_poly(input hpe_pkg::word_t x);
        poly_result_t res;
        longint acc;
        longint sum;
        res.ovf = 1'b0;
        acc = longint'(coef_model[DEGREE]);
        for (int k = DEGREE - 1; k >= 0; k--)
        begin
            sum = ((acc * longint'(x)) >>> FRAC) + longint'(coef_model[k]);
            if (sum > longint'(WORD_MAX))
            begin
                sum = longint'(WORD_MAX);
                res.ovf = 1'b1;
            end
            else if (sum < longint'(WORD_MIN))
            begin
                sum = longint'(WORD_MIN);
                res.ovf = 1'b1;
            end
            acc = sum;
        end
        res.y = hpe_pkg::word_t'(acc);
        return res;
    endfunction

    // Mostly small magnitudes so that deep polynomials stay in range,
    // with some full-width values and limits mixed in.
    function automatic hpe_pkg::word_t rand_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return ONE_LSB;
                3: return MINUS_LSB;
                default: return '0;
            endcase
        end
        else if (pick < 70)
            return hpe_pkg::word_t'($urandom_range(0, 32'h7FFFF)) - 32'sh4_0000;
        else if (pick < 85)
            return hpe_pkg::word_t'($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
        return hpe_pkg::word_t'($urandom);
    endfunction

    // Result checking and prediction, both on the rising edge.
    always @(posedge clk)
    begin : result_check
        poly_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_values.size() == 0)
                begin
                    $error("result with nothing expected: y_value %0d overflow %0b",
                           y_value, overflow);
                    fail_count++;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (y_value !== want.y)
                    begin
                        $error("y_value expected %0d actual %0d", want.y, y_value);
                        fail_count++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow expected %0b actual %0b", want.ovf, overflow);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (drv_typed)
                    pending_values.push_back('{drv_y, drv_ovf});
                else
                    pending_values.push_back(eval_poly(x_value));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called and returns just after a falling edge.
    task automatic send_point(input hpe_pkg::word_t x, input logic typed,
                              input hpe_pkg::word_t y, input logic ovf,
                              input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            x_value <= hpe_pkg::word_t'($urandom);
            @(negedge clk);
        end
        start     <= 1'b1;
        x_value   <= x;
        drv_typed <= typed;
        drv_y     <= y;
        drv_ovf   <= ovf;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start     <= 1'b0;
        drv_typed <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input int idx,
                                input hpe_pkg::word_t wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= hpe_pkg::ADDR_W'(idx * COEF_STRIDE);
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes every coefficient, then reads each one back.
    task automatic load_coefs(input hpe_pkg::word_t c [hpe_pkg::NUM_COEF]);
        logic [31:0] rdata;
        for (int i = 0; i < hpe_pkg::NUM_COEF; i++)
        begin
            apb_transfer(1'b1, i, c[i], rdata);
            coef_model[i] = c[i];
        end
        for (int i = 0; i < hpe_pkg::NUM_COEF; i++)
        begin
            apb_transfer(1'b0, i, '0, rdata);
            if (rdata !== coef_model[i])
            begin
                $error("prdata expected %08h actual %08h", coef_model[i], rdata);
                fail_count++;
            end
        end
    endtask

    initial
    begin : stimulus
        hpe_pkg::word_t rand_coefs [hpe_pkg::NUM_COEF];
        int unsigned    cur_sel;
        int unsigned    top_term;
        int             idle_pct;
        for (int i = 0; i < hpe_pkg::NUM_COEF; i++)
            coef_model[i] = '0;
        cur_sel = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].coef_sel != cur_sel)
            begin
                drain_results();
                cur_sel = directed_rows[r].coef_sel;
                load_coefs(coef_sets[cur_sel]);
            end
            send_point(directed_rows[r].x, directed_rows[r].typed, directed_rows[r].y,
                       directed_rows[r].ovf, 0);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            // Zero leading terms give each phase a random effective degree.
            top_term = $urandom_range(DEGREE);
            for (int k = 0; k < hpe_pkg::NUM_COEF; k++)
                rand_coefs[k] = (k <= top_term) ? rand_word() : hpe_pkg::word_t'(0);
            load_coefs(rand_coefs);
            idle_pct = idle_schedule[ph % 3];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_point(rand_word(), 1'b0, '0, 1'b0, idle_pct);
        end

        drain_results();
        repeat (2 * DEGREE + 6) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ horner_polynomial_evaluator.f @@
+incdir+rtl
rtl/hpe_pkg.sv
rtl/hpe_regs.sv
rtl/hpe_cell.sv
rtl/horner_polynomial_evaluator.sv
tb/testbench.sv
